FILE: design/green_power_frame_header_parser_macros.svh
// Assertion macros for the green power frame header parser.
// Used by the top level; the clock is clk and the reset is rst in every user.
`ifndef GREEN_POWER_FRAME_HEADER_PARSER_MACROS_SVH
`define GREEN_POWER_FRAME_HEADER_PARSER_MACROS_SVH

`ifndef SYNTHESIS
`define GPFHP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gpfhp: same-cycle check failed");
`define GPFHP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gpfhp: next-cycle check failed");
`else
`define GPFHP_ASSERT_SAME(lbl, ante, cons)
`define GPFHP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: design/gpfhp_pkg.sv
// Shared types, constants and the header layout decoder for the parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package gpfhp_pkg;

  localparam int MaxFrameBytes = 127;
  localparam int IdxW          = 7;
  localparam int QueueDepth    = 2;

  localparam logic [7:0] ProtoMask   = 8'h7c;
  localparam logic [7:0] MaintExt    = 8'h81;
  localparam logic [7:0] SecMask     = 8'h18;
  localparam logic [7:0] SecReserved = 8'h08;
  localparam logic [1:0] FtMaint     = 2'd1;

  localparam logic [2:0] APP_SRC  = 3'd0;
  localparam logic [2:0] APP_IEEE = 3'd2;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_APP     = 3'd1,
    ST_OUTGOING    = 3'd2,
    ST_SHORT       = 3'd3,
    ST_NO_EXT_ADDR = 3'd4,
    ST_RSVD_SEC    = 3'd5,
    ST_SHORT_MIC   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    KIND_CTRL = 2'd0,
    KIND_EXT  = 2'd1,
    KIND_BODY = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0]      data;
    logic            last;
    logic            src_ext;
    logic [IdxW-1:0] idx;
    kind_t           kind;
  } item_t;

  typedef struct packed {
    logic       has_ext;
    logic [2:0] app;
    logic [1:0] sec;
    logic       has_src;
    logic [1:0] src_at;
    logic       has_ep;
    logic [2:0] ep_at;
    logic       has_cnt;
    logic [3:0] cnt_at;
    logic [3:0] hdr;
  } layout_t;

  // Field positions implied by the control and extended control bytes.
  function automatic layout_t get_layout(logic [7:0] ctrl, logic [7:0] ext);
    layout_t    l;
    logic [3:0] pos;
    l.has_ext = ctrl[7];
    l.app     = l.has_ext ? ext[2:0] : APP_SRC;
    l.sec     = l.has_ext ? ext[4:3] : 2'd0;
    pos       = l.has_ext ? 4'd2 : 4'd1;
    l.has_src = ((ctrl[1:0] == 2'd0) && (l.app == APP_SRC)) ||
                (((ctrl & ~ProtoMask) == MaintExt) && (l.app == APP_SRC));
    l.src_at  = pos[1:0];
    if (l.has_src) pos = pos + 4'd4;
    l.has_ep  = (l.app == APP_IEEE);
    l.ep_at   = pos[2:0];
    if (l.has_ep) pos = pos + 4'd1;
    l.has_cnt = l.has_ext && l.sec[1];
    l.cnt_at  = pos;
    if (l.has_cnt) pos = pos + 4'd4;
    l.hdr     = pos;
    return l;
  endfunction

endpackage

FILE: design/green_power_frame_header_parser.sv
// Top level of the green power frame header parser: front, queue and back end.
// Depends on gpfhp_pkg, gpfhp_front, gpfhp_queue, gpfhp_back and the macros header.
//
//   channel | direction | payload                                  | handshake
//   in      | to block  | data_byte, last, src_ext_addr            | in_valid / in_stall
//   out     | from block| status .. payload_len (one per frame)    | out_valid / out_stall
//
// One byte per cycle while the input is not stalled; a final byte is written into the queue,
// and its result is loaded into the output register when the back end pops it from the head.
// The input stalls only when the two-entry queue is full; the back end holds a
// final byte in the queue while an earlier result is stalled in the output register.
// Synchronous reset clears the position counter, queue, frame state and out_valid.
`timescale 1ns / 1ps
`include "green_power_frame_header_parser_macros.svh"

module green_power_frame_header_parser #(
  parameter int MAX_FRAME_BYTES = gpfhp_pkg::MaxFrameBytes
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last,
  input  logic        src_ext_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [1:0]  frame_type,
  output logic [2:0]  app_id,
  output logic [2:0]  flags,
  output logic [1:0]  sec_level,
  output logic [31:0] source_id,
  output logic [7:0]  endpoint_num,
  output logic [31:0] frame_counter,
  output logic [31:0] mic_value,
  output logic [3:0]  header_len,
  output logic [6:0]  payload_len
);
  import gpfhp_pkg::*;

  logic  q_push, q_full, q_pop, q_head_valid;
  item_t q_item, q_head;

  gpfhp_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last         (last),
    .src_ext_addr (src_ext_addr),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_item)
  );

  gpfhp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .item_in    (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  gpfhp_back #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (q_head_valid),
    .head          (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .frame_type    (frame_type),
    .app_id        (app_id),
    .flags         (flags),
    .sec_level     (sec_level),
    .source_id     (source_id),
    .endpoint_num  (endpoint_num),
    .frame_counter (frame_counter),
    .mic_value     (mic_value),
    .header_len    (header_len),
    .payload_len   (payload_len)
  );

  `GPFHP_ASSERT_SAME(a_no_overflow, q_push, !q_full)
  `GPFHP_ASSERT_SAME(a_hold_final, q_head_valid && q_head.last && out_valid && out_stall, !q_pop)
  `GPFHP_ASSERT_NEXT(a_result_after_final, q_pop && q_head.last, out_valid)

endmodule

FILE: design/gpfhp_front.sv
// Front end: accepts frame bytes, counts the position and tags each item.
// Depends on gpfhp_pkg; feeds gpfhp_queue.
`timescale 1ns / 1ps

module gpfhp_front #(
  parameter int MAX_FRAME_BYTES = gpfhp_pkg::MaxFrameBytes
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                last,
  input  logic                src_ext_addr,
  input  logic                q_full,
  output logic                q_push,
  output gpfhp_pkg::item_t    q_item
);
  import gpfhp_pkg::*;

  localparam logic [IdxW-1:0] IdxMax = IdxW'(MAX_FRAME_BYTES);

  logic [IdxW-1:0] idx, idx_next;
  logic            ext_flag, ext_flag_next;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.data    = data_byte;
    q_item.last    = last;
    q_item.src_ext = src_ext_addr;
    q_item.idx     = idx;
    if (idx == '0) begin
      q_item.kind = KIND_CTRL;
    end else if (idx == IdxW'(1) && ext_flag) begin
      q_item.kind = KIND_EXT;
    end else begin
      q_item.kind = KIND_BODY;
    end
  end

  always_comb begin
    idx_next      = idx;
    ext_flag_next = ext_flag;
    if (q_push) begin
      if (idx == '0) ext_flag_next = data_byte[7];
      if (last) begin
        idx_next      = '0;
        ext_flag_next = 1'b0;
      end else if (idx != IdxMax) begin
        idx_next = idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      ext_flag <= 1'b0;
    end else begin
      idx      <= idx_next;
      ext_flag <= ext_flag_next;
    end
  end

endmodule

FILE: design/gpfhp_queue.sv
// Short item queue between the front end and the back end.
// Depends on gpfhp_pkg for the item type and depth.
`timescale 1ns / 1ps

module gpfhp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  gpfhp_pkg::item_t item_in,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output gpfhp_pkg::item_t head
);
  import gpfhp_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  item_t           slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [PtrW:0]   count, count_next;

  assign full       = (count == (PtrW + 1)'(QueueDepth));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + 1'b1;
    else if (pop && !push) count_next = count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= item_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count_next;
    end
  end

endmodule

FILE: design/gpfhp_back.sv
// Back end: collects header fields from queued items and builds the result.
// Depends on gpfhp_pkg; drains gpfhp_queue and drives the output register.
`timescale 1ns / 1ps

module gpfhp_back #(
  parameter int MAX_FRAME_BYTES = gpfhp_pkg::MaxFrameBytes
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  gpfhp_pkg::item_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       status,
  output logic [1:0]       frame_type,
  output logic [2:0]       app_id,
  output logic [2:0]       flags,
  output logic [1:0]       sec_level,
  output logic [31:0]      source_id,
  output logic [7:0]       endpoint_num,
  output logic [31:0]      frame_counter,
  output logic [31:0]      mic_value,
  output logic [3:0]       header_len,
  output logic [6:0]       payload_len
);
  import gpfhp_pkg::*;

  localparam logic [IdxW-1:0] IdxMax = IdxW'(MAX_FRAME_BYTES);

  logic [7:0]  ctrl, ctrl_next;
  logic [7:0]  ext, ext_next;
  logic [31:0] src, src_next;
  logic [7:0]  ep, ep_next;
  logic [31:0] cnt, cnt_next;
  logic [31:0] tail, tail_next;
  status_t     err, err_next;

  layout_t         lay, lay_next;
  logic [IdxW-1:0] src_off, cnt_off, len, hdr_w, rem;
  logic            mic_present;
  status_t         res_status;
  logic [2:0]      res_app;
  logic [6:0]      res_payload;
  logic [31:0]     res_mic, res_src, res_cnt;
  logic [7:0]      res_ep;
  logic [3:0]      res_hdr;

  // a final byte waits until the output register can take its result
  assign pop = head_valid && (!head.last || !out_valid || !out_stall);

  always_comb begin
    lay       = get_layout(ctrl, ext);
    ctrl_next = ctrl;
    ext_next  = ext;
    src_next  = src;
    ep_next   = ep;
    cnt_next  = cnt;
    err_next  = err;
    tail_next = {head.data, tail[31:8]};
    src_off   = head.idx - IdxW'(lay.src_at);
    cnt_off   = head.idx - IdxW'(lay.cnt_at);
    case (head.kind)
      KIND_CTRL: ctrl_next = head.data;
      KIND_EXT: begin
        ext_next = head.data;
        if (head.data[2:0] != APP_SRC && head.data[2:0] != APP_IEEE) begin
          err_next = ST_BAD_APP;
        end else if (head.data[7]) begin
          err_next = ST_OUTGOING;
        end
      end
      default: begin
        if (lay.has_src && head.idx >= IdxW'(lay.src_at) && src_off < IdxW'(4)) begin
          src_next = src | ({24'd0, head.data} << {src_off[1:0], 3'b000});
        end
        if (lay.has_ep && head.idx == IdxW'(lay.ep_at)) ep_next = head.data;
        if (lay.has_cnt && head.idx >= IdxW'(lay.cnt_at) && cnt_off < IdxW'(4)) begin
          cnt_next = cnt | ({24'd0, head.data} << {cnt_off[1:0], 3'b000});
        end
      end
    endcase
  end

  // result of a frame whose final byte is at the queue head
  always_comb begin
    lay_next    = get_layout(ctrl_next, ext_next);
    len         = (head.idx == IdxMax) ? IdxMax : head.idx + 1'b1;
    hdr_w       = IdxW'(lay_next.hdr);
    rem         = len - hdr_w;
    mic_present = lay_next.has_ext && (lay_next.app != APP_SRC) && lay_next.sec[1];
    res_hdr     = lay_next.hdr;
    res_src     = lay_next.has_src ? src_next : 32'd0;
    res_ep      = lay_next.has_ep ? ep_next : 8'd0;
    res_cnt     = lay_next.has_cnt ? cnt_next : 32'd0;
    res_payload = 7'd0;
    res_mic     = 32'd0;
    if (err_next != ST_OK) begin
      res_status = err_next;
      res_hdr    = 4'd0;
      res_src    = 32'd0;
      res_ep     = 8'd0;
      res_cnt    = 32'd0;
    end else if (hdr_w >= len) begin
      res_status = ST_SHORT;
    end else if (lay_next.has_ext && lay_next.app == APP_IEEE && !head.src_ext) begin
      res_status = ST_NO_EXT_ADDR;
    end else if (mic_present && rem < IdxW'(4)) begin
      res_status = ST_SHORT_MIC;
    end else if (lay_next.has_ext && (ext_next & SecMask) == SecReserved) begin
      res_status = ST_RSVD_SEC;
    end else begin
      res_status = ST_OK;
      if (mic_present) begin
        res_payload = 7'(rem - IdxW'(4));
        res_mic     = tail_next;
      end else begin
        res_payload = 7'(rem);
      end
    end
    res_app = lay_next.app;
    // ok/rsvd/mic maintenance frame, no auto-commissioning: source-id app
    if ((res_status inside {ST_OK, ST_RSVD_SEC, ST_SHORT_MIC}) &&
        ctrl_next[1:0] == FtMaint && !ctrl_next[6]) begin
      res_app = APP_SRC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ctrl      <= '0;
      ext       <= '0;
      src       <= '0;
      ep        <= '0;
      cnt       <= '0;
      tail      <= '0;
      err       <= ST_OK;
    end else begin
      // load a new result, or hold one that is still stalled
      out_valid <= (pop && head.last) || (out_valid && out_stall);
      if (pop) begin
        if (head.last) begin
          ctrl      <= '0;
          ext       <= '0;
          src       <= '0;
          ep        <= '0;
          cnt       <= '0;
          tail      <= '0;
          err       <= ST_OK;
        end else begin
          ctrl <= ctrl_next;
          ext  <= ext_next;
          src  <= src_next;
          ep   <= ep_next;
          cnt  <= cnt_next;
          tail <= tail_next;
          err  <= err_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      status        <= res_status;
      frame_type    <= ctrl_next[1:0];
      app_id        <= res_app;
      flags         <= {lay_next.has_ext & ext_next[5], lay_next.has_ext & ext_next[6],
                        ctrl_next[6]};
      sec_level     <= lay_next.sec;
      source_id     <= res_src;
      endpoint_num  <= res_ep;
      frame_counter <= res_cnt;
      mic_value     <= res_mic;
      header_len    <= res_hdr;
      payload_len   <= res_payload;
    end
  end

endmodule

FILE: sim/green_power_frame_header_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for green_power_frame_header_parser: frames go in as bytes and every
// frame result is compared with a predictor kept inside the bench. Depends on gpfhp_pkg.

module green_power_frame_header_parser_tb;
  import gpfhp_pkg::*;

  localparam int RandomItems   = 1550;
  localparam int PhaseItems    = 520;
  localparam int HoldAtItem    = 1150;
  localparam int HoldCycles    = 400;
  localparam int DrainCycles   = 10;
  localparam int MicBytes      = 4;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       addr_mode;
  } rx_byte_t;

  typedef struct packed {
    status_t     status;
    logic [1:0]  ft;
    logic [2:0]  app;
    logic [2:0]  flg;
    logic [1:0]  sec;
    logic [31:0] src;
    logic [7:0]  ep;
    logic [31:0] cnt;
    logic [31:0] mic;
    logic [3:0]  hdr;
    logic [6:0]  pay;
  } frame_result_t;

  typedef struct {
    bit       has_ext;
    bit [2:0] app;
    bit [1:0] sec;
    bit       has_src;
    int       src_pos;
    bit       has_ep;
    int       ep_pos;
    bit       has_cnt;
    int       cnt_pos;
    int       hdr;
  } hdr_map_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        last = 1'b0;
  logic        src_ext_addr = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [1:0]  frame_type;
  logic [2:0]  app_id;
  logic [2:0]  flags;
  logic [1:0]  sec_level;
  logic [31:0] source_id;
  logic [7:0]  endpoint_num;
  logic [31:0] frame_counter;
  logic [31:0] mic_value;
  logic [3:0]  header_len;
  logic [6:0]  payload_len;

  green_power_frame_header_parser dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last         (last),
    .src_ext_addr (src_ext_addr),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .frame_type   (frame_type),
    .app_id       (app_id),
    .flags        (flags),
    .sec_level    (sec_level),
    .source_id    (source_id),
    .endpoint_num (endpoint_num),
    .frame_counter(frame_counter),
    .mic_value    (mic_value),
    .header_len   (header_len),
    .payload_len  (payload_len)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rx_byte_t      byte_q[$];
  frame_result_t pending_results[$];
  rx_byte_t      next_byte;

  // Predictor frame state
  int          frm_len;
  logic [7:0]  frm_ctrl;
  logic [7:0]  frm_ext;
  logic [31:0] frm_src;
  logic [7:0]  frm_ep;
  logic [31:0] frm_cnt;
  logic [31:0] frm_tail;
  status_t     frm_err;

  int items_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int overlong_frames = 0;
  int input_stall_cycles = 0;
  int backpressure_left = 0;
  bit backpressure_done = 1'b0;
  int status_count[8];

  function automatic hdr_map_t header_map(input logic [7:0] c, input logic [7:0] e);
    hdr_map_t m;
    int       pos;
    m.has_ext = c[7];
    m.app     = m.has_ext ? e[2:0] : APP_SRC;
    m.sec     = m.has_ext ? e[4:3] : 2'd0;
    pos       = m.has_ext ? 2 : 1;
    m.has_src = (m.app == APP_SRC) && ((c[1:0] == 2'd0) || ((c & ~ProtoMask) == MaintExt));
    m.src_pos = pos;
    if (m.has_src) pos += 4;
    m.has_ep  = (m.app == APP_IEEE);
    m.ep_pos  = pos;
    if (m.has_ep) pos += 1;
    m.has_cnt = m.has_ext && (m.sec > 2'd1);
    m.cnt_pos = pos;
    if (m.has_cnt) pos += 4;
    m.hdr     = pos;
    return m;
  endfunction

  function automatic int sender_gap_pct(input int n);
    if (n < PhaseItems) return 34;
    if (n < 2 * PhaseItems) return 48;
    return 0;
  endfunction

  function automatic int receiver_stall_pct(input int n);
    if (n < PhaseItems) return 48;
    if (n < 2 * PhaseItems) return 34;
    return 0;
  endfunction

  task automatic clear_frame_state();
    frm_len  = 0;
    frm_ctrl = '0;
    frm_ext  = '0;
    frm_src  = '0;
    frm_ep   = '0;
    frm_cnt  = '0;
    frm_tail = '0;
    frm_err  = ST_OK;
  endtask

  // Advance the frame state by one byte; on the final byte queue the expected result.
  task automatic parse_byte(input rx_byte_t b);
    hdr_map_t      m;
    frame_result_t r;
    int            i;
    int            n;
    bit            mic_on;
    i = frm_len;
    if (i == 0) begin
      frm_ctrl = b.data;
    end else if (i == 1 && frm_ctrl[7]) begin
      frm_ext = b.data;
      if (b.data[2:0] != APP_SRC && b.data[2:0] != APP_IEEE) frm_err = ST_BAD_APP;
      else if (b.data[7]) frm_err = ST_OUTGOING;
    end else begin
      m = header_map(frm_ctrl, frm_ext);
      if (m.has_src && i >= m.src_pos && i < m.src_pos + 4)
        frm_src |= 32'(b.data) << (8 * (i - m.src_pos));
      if (m.has_ep && i == m.ep_pos) frm_ep = b.data;
      if (m.has_cnt && i >= m.cnt_pos && i < m.cnt_pos + 4)
        frm_cnt |= 32'(b.data) << (8 * (i - m.cnt_pos));
    end
    frm_tail = {b.data, frm_tail[31:8]};
    if (frm_len < MaxFrameBytes) frm_len++;
    if (!b.fin) return;

    n      = frm_len;
    m      = header_map(frm_ctrl, frm_ext);
    mic_on = m.has_ext && (m.app != APP_SRC) && (m.sec > 2'd1);
    r      = '0;
    r.ft   = frm_ctrl[1:0];
    r.app  = m.app;
    r.sec  = m.sec;
    r.flg  = {m.has_ext & frm_ext[5], m.has_ext & frm_ext[6], frm_ctrl[6]};
    if (frm_err != ST_OK) begin
      r.status = frm_err;
    end else begin
      r.hdr = 4'(m.hdr);
      r.src = m.has_src ? frm_src : 32'd0;
      r.ep  = m.has_ep ? frm_ep : 8'd0;
      r.cnt = m.has_cnt ? frm_cnt : 32'd0;
      if (m.hdr >= n) begin
        r.status = ST_SHORT;
      end else if (m.has_ext && m.app == APP_IEEE && !b.addr_mode) begin
        r.status = ST_NO_EXT_ADDR;
      end else if (mic_on && (n - m.hdr) < MicBytes) begin
        r.status = ST_SHORT_MIC;
      end else if (m.has_ext && (frm_ext & SecMask) == SecReserved) begin
        r.status = ST_RSVD_SEC;
      end else begin
        r.status = ST_OK;
        r.pay    = 7'(n - m.hdr - (mic_on ? MicBytes : 0));
        if (mic_on) r.mic = frm_tail;
      end
    end
    // Maintenance frames without auto-commissioning report the source app id (ok/rsvd/mic)
    if ((r.status == ST_OK || r.status == ST_RSVD_SEC || r.status == ST_SHORT_MIC) &&
        frm_ctrl[1:0] == FtMaint && !frm_ctrl[6])
      r.app = APP_SRC;
    pending_results.push_back(r);
    clear_frame_state();
  endtask

  task automatic queue_frame(input logic [7:0] fb[$], input logic mode);
    rx_byte_t it;
    for (int k = 0; k < fb.size(); k++) begin
      it.data      = fb[k];
      it.fin       = (k == fb.size() - 1);
      it.addr_mode = it.fin ? mode : 1'($urandom);
      byte_q.push_back(it);
    end
  endtask

  // Mostly well-formed frames with random content, some noise, truncated and overlong frames.
  task automatic add_random_frame();
    logic [7:0] fb[$];
    logic [7:0] c;
    logic [7:0] e;
    hdr_map_t   m;
    int         total;
    int         pick;
    int         app_pick;
    bit         mic_on;
    pick = $urandom_range(99);
    if (pick < 12) begin
      total = $urandom_range(1, 10);
      repeat (total) fb.push_back(8'($urandom));
    end else begin
      c      = 8'($urandom);
      c[1:0] = ($urandom_range(3) == 0) ? 2'($urandom) : 2'($urandom_range(1));
      c[7]   = ($urandom_range(9) < 7);
      e      = 8'($urandom);
      app_pick = $urandom_range(9);
      if (app_pick < 4) e[2:0] = APP_SRC;
      else if (app_pick < 8) e[2:0] = APP_IEEE;
      e[7]   = ($urandom_range(19) == 0);
      m      = header_map(c, e);
      mic_on = m.has_ext && (m.app != APP_SRC) && (m.sec > 2'd1);
      if (pick < 13 && overlong_frames < 3) begin
        total = $urandom_range(128, 140);
        overlong_frames++;
      end else if (pick < 25) begin
        total = $urandom_range(1, m.hdr + MicBytes);
      end else begin
        total = m.hdr + (mic_on ? MicBytes : 0) + $urandom_range(0, 16);
      end
      fb.push_back(c);
      if (c[7] && total > 1) fb.push_back(e);
      while (fb.size() < total) fb.push_back(8'($urandom));
    end
    queue_frame(fb, $urandom_range(9) != 0);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    frame_result_t r;
    if (pending_results.size() == 0) begin
      $display("%0t: result with none expected, expected nothing actual status %0h",
               $time, status);
      mismatches++;
      return;
    end
    r = pending_results.pop_front();
    results_seen++;
    status_count[r.status]++;
    compare_field("status", r.status, status);
    compare_field("frame_type", r.ft, frame_type);
    compare_field("app_id", r.app, app_id);
    compare_field("flags", r.flg, flags);
    compare_field("sec_level", r.sec, sec_level);
    compare_field("source_id", r.src, source_id);
    compare_field("endpoint_num", r.ep, endpoint_num);
    compare_field("frame_counter", r.cnt, frame_counter);
    compare_field("mic_value", r.mic, mic_value);
    compare_field("header_len", r.hdr, header_len);
    compare_field("payload_len", r.pay, payload_len);
  endtask

  // Driver: hold a stalled item, otherwise move to the next one or idle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        parse_byte({data_byte, last, src_ext_addr});
        items_taken <= items_taken + 1;
      end
      if (byte_q.size() != 0 && $urandom_range(99) >= sender_gap_pct(items_taken)) begin
        next_byte = byte_q.pop_front();
        in_valid     <= 1'b1;
        data_byte    <= next_byte.data;
        last         <= next_byte.fin;
        src_ext_addr <= next_byte.addr_mode;
      end else begin
        in_valid <= 1'b0;
      end
    end else begin
      input_stall_cycles <= input_stall_cycles + 1;
    end
  end

  // Long receiver hold-off once, so the queue inside the block fills up.
  always @(posedge clk) begin
    if (rst) begin
      backpressure_left <= 0;
    end else if (!backpressure_done && items_taken >= HoldAtItem) begin
      backpressure_done <= 1'b1;
      backpressure_left <= HoldCycles;
    end else if (backpressure_left != 0) begin
      backpressure_left <= backpressure_left - 1;
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      out_stall <= (backpressure_left != 0) ||
                   ($urandom_range(99) < receiver_stall_pct(items_taken));
    end
  end

  initial begin
    logic [7:0] fb[$];
    clear_frame_state();
    // Directed frames: missing extended byte, bad app id, outgoing direction,
    // IEEE app without extended address, reserved security, too short for MIC,
    // all-ones and all-zeros single bytes.
    fb = '{8'h80};                                         queue_frame(fb, 1'b1);
    fb = '{8'h81, 8'h01, 8'haa};                           queue_frame(fb, 1'b1);
    fb = '{8'h80, 8'h80, 8'h00};                           queue_frame(fb, 1'b1);
    fb = '{8'h80, 8'h02, 8'h05, 8'hff};                    queue_frame(fb, 1'b0);
    fb = '{8'h82, 8'h08, 8'h00};                           queue_frame(fb, 1'b1);
    fb = '{8'h82, 8'h12, 8'h05, 8'h01, 8'h02, 8'h03, 8'h04, 8'h77};
    queue_frame(fb, 1'b1);
    fb = '{8'hff};                                         queue_frame(fb, 1'b0);
    fb = '{8'h00};                                         queue_frame(fb, 1'b1);
    while (byte_q.size() < RandomItems) add_random_frame();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (byte_q.size() != 0 || in_valid) @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("Checked %0d frame results over %0d bytes, %0d overlong frames, input stalled %0d cycles",
             results_seen, items_taken, overlong_frames, input_stall_cycles);
    $display("Status counts ok/app/dir/short/addr/rsvd/mic: %0d %0d %0d %0d %0d %0d %0d",
             status_count[ST_OK], status_count[ST_BAD_APP], status_count[ST_OUTGOING],
             status_count[ST_SHORT], status_count[ST_NO_EXT_ADDR], status_count[ST_RSVD_SEC],
             status_count[ST_SHORT_MIC]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/gpfhp_pkg.sv
design/gpfhp_front.sv
design/gpfhp_queue.sv
design/gpfhp_back.sv
design/green_power_frame_header_parser.sv
sim/green_power_frame_header_parser_tb.sv
